### design/iff_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared constants, codes, the emission plan structure and the digit
// character function used by the converter and the emitter.
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int BIN_W       = 64;              // width of the incoming value
    localparam int DIGIT_SLOTS = 22;              // enough for 64-bit octal
    localparam int DIG_W       = 4 * DIGIT_SLOTS; // nibble-per-digit register
    localparam int MAX_FIELD   = 64;
    localparam int PREC_CAP    = MAX_FIELD - 4;

    // Radix codes; any other code converts as decimal.
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    // Everything the emitter needs to lay out one field.
    typedef struct packed {
        logic [6:0]       lead_sp;
        logic             sign_en;
        logic [7:0]       sign_char;
        logic             pre_zero;
        logic             pre_x;
        logic [7:0]       x_char;
        logic [6:0]       zeros;
        logic [4:0]       len;
        logic [6:0]       trail_sp;
        logic [6:0]       total;
        logic             upper;
        logic [DIG_W-1:0] digits;   // most significant digit at the top
    } t_plan;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10) begin
                c = CH_ZERO + {4'd0, d};
            end else if (upper) begin
                c = CH_A_UP + {4'd0, d} - 8'd10;
            end else begin
                c = CH_A_LO + {4'd0, d} - 8'd10;
            end
            return c;
        end
    endfunction

endpackage

### design/iff_emitter.sv
// ----------------------------------------------------------------------------
// Integer field formatter emitter
// Walks an emission plan and sends one character per transfer through a
// registered output stage.
// ----------------------------------------------------------------------------
module iff_emitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  iff_pkg::t_plan i_plan,
    output logic          o_busy,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_text_char,
    output logic          o_last_char
);

    iff_pkg::t_plan r_plan;
    iff_pkg::t_plan n_plan;
    logic [6:0]     r_rem;
    logic [6:0]     n_rem;
    logic           r_busy;
    logic           n_busy;
    logic           r_valid;
    logic           n_valid;
    logic [7:0]     r_char;
    logic [7:0]     n_char;
    logic           r_last;
    logic           n_last;
    logic           load;

    assign load = r_busy && (!r_valid || !i_stall);

    always_comb begin
        n_plan  = r_plan;
        n_rem   = r_rem;
        n_busy  = r_busy;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_last  = (r_rem == 7'd1);
            n_rem   = r_rem - 7'd1;
            if (r_rem == 7'd1) begin
                n_busy = 1'b0;
            end
            // Segments in field order: spaces, sign, prefix, zero fill,
            // digits, trailing spaces.
            if (r_plan.lead_sp != 7'd0) begin
                n_char          = iff_pkg::CH_SPACE;
                n_plan.lead_sp  = r_plan.lead_sp - 7'd1;
            end else if (r_plan.sign_en) begin
                n_char          = r_plan.sign_char;
                n_plan.sign_en  = 1'b0;
            end else if (r_plan.pre_zero) begin
                n_char          = iff_pkg::CH_ZERO;
                n_plan.pre_zero = 1'b0;
            end else if (r_plan.pre_x) begin
                n_char          = r_plan.x_char;
                n_plan.pre_x    = 1'b0;
            end else if (r_plan.zeros != 7'd0) begin
                n_char          = iff_pkg::CH_ZERO;
                n_plan.zeros    = r_plan.zeros - 7'd1;
            end else if (r_plan.len != 5'd0) begin
                n_char          = iff_pkg::digit_char(
                                      r_plan.digits[iff_pkg::DIG_W-1 -: 4], r_plan.upper);
                n_plan.digits   = {r_plan.digits[iff_pkg::DIG_W-5:0], 4'd0};
                n_plan.len      = r_plan.len - 5'd1;
            end else begin
                n_char          = iff_pkg::CH_SPACE;
                n_plan.trail_sp = r_plan.trail_sp - 7'd1;
            end
        end
        if (i_start && !r_busy) begin
            n_plan = i_plan;
            n_rem  = i_plan.total;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_rem   <= 7'd0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_rem   <= n_rem;
        end
        r_plan <= n_plan;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_busy      = r_busy;
    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

### design/integer_field_formatter.sv
// Sequence: after its transfer a hex or octal item goes through the digit scan (shifts until the
// leading digit is found), the planning state and the emitter load before the first character is
// offered; decimal items first pass through the shift-and-adjust steps of double dabble.
// Throughput: one character per cycle while i_stall is low; the field length N is 1 to 64.
// Conversion of the next item overlaps emission of the current one.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
// Integer field formatter
// Converts one 64-bit integer with printf-style options into its text, sent
// one ASCII character per output transfer with a marker on the final one.
// ----------------------------------------------------------------------------
module integer_field_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_number,
    input  logic        i_signed_conv,
    input  logic [1:0]  i_radix_select,
    input  logic [6:0]  i_field_width,
    input  logic [5:0]  i_min_digits,
    input  logic        i_precision_given,
    input  logic        i_zero_pad,
    input  logic        i_left_justify,
    input  logic        i_force_plus,
    input  logic        i_space_sign,
    input  logic        i_alternate_form,
    input  logic        i_upper_case,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_char,
    output logic        o_last_char
);

    // The sequencer owns one shared shifter over the digit register. In the
    // decimal case it runs as a double-dabble converter, one value bit per
    // cycle; in every radix it then shifts leading zero digits out, one
    // digit per cycle, which gives the digit count.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DABBLE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_PLAN   = 4'b1000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [iff_pkg::DIG_W-1:0]    r_dig;
    logic [iff_pkg::DIG_W-1:0]    n_dig;
    logic [iff_pkg::BIN_W-1:0]    r_bin;
    logic [iff_pkg::BIN_W-1:0]    n_bin;
    logic [6:0]                   r_step;
    logic [6:0]                   n_step;
    logic [4:0]                   r_len;
    logic [4:0]                   n_len;

    // Options held for the planning cycle.
    logic       r_neg;
    logic       r_nonzero;
    logic [1:0] r_radix;
    logic [6:0] r_fwidth;
    logic [5:0] r_prec;
    logic       r_pgiven;
    logic       r_zpad;
    logic       r_left;
    logic       r_plus;
    logic       r_space;
    logic       r_alt;
    logic       r_upper;

    logic                         accept;
    logic                         is_hex;
    logic                         is_oct;
    logic                         in_neg;
    logic [iff_pkg::BIN_W-1:0]    mag;
    logic [iff_pkg::BIN_W+1:0]    mag_x;
    logic [iff_pkg::DIG_W-1:0]    dig_oct;
    logic [iff_pkg::DIG_W-1:0]    dig_adj;

    iff_pkg::t_plan               plan;
    logic                         emit_busy;
    logic                         start;

    assign accept = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    assign is_hex = (i_radix_select == iff_pkg::RADIX_HEX);
    assign is_oct = (i_radix_select == iff_pkg::RADIX_OCT);
    // Only decimal honours the signed flag; the negation wraps, so the most
    // negative value comes out as its true magnitude.
    assign in_neg = i_signed_conv && !is_hex && !is_oct && i_number[iff_pkg::BIN_W-1];
    assign mag    = in_neg ? (~i_number + 64'd1) : i_number;
    assign mag_x  = {2'b00, mag};

    // Octal digits are three bits each, widened to one nibble per digit.
    always_comb begin
        for (int k = 0; k < iff_pkg::DIGIT_SLOTS; k++) begin
            dig_oct[4*k +: 4] = {1'b0, mag_x[3*k +: 3]};
        end
    end

    // Double-dabble adjust: every BCD digit of five or more gets three added
    // before the shift, so the shift carries correctly into the next digit.
    always_comb begin
        for (int k = 0; k < iff_pkg::DIGIT_SLOTS; k++) begin
            if (r_dig[4*k +: 4] >= 4'd5) begin
                dig_adj[4*k +: 4] = r_dig[4*k +: 4] + 4'd3;
            end else begin
                dig_adj[4*k +: 4] = r_dig[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_step  = r_step;
        n_len   = r_len;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_len = 5'(iff_pkg::DIGIT_SLOTS);
                    n_bin = mag;
                    if (is_hex) begin
                        n_dig   = {{(iff_pkg::DIG_W-iff_pkg::BIN_W){1'b0}}, mag};
                        n_state = S_SCAN;
                    end else if (is_oct) begin
                        n_dig   = dig_oct;
                        n_state = S_SCAN;
                    end else begin
                        n_dig   = '0;
                        n_step  = 7'(iff_pkg::BIN_W);
                        n_state = S_DABBLE;
                    end
                end
            end
            S_DABBLE: begin
                n_dig  = {dig_adj[iff_pkg::DIG_W-2:0], r_bin[iff_pkg::BIN_W-1]};
                n_bin  = {r_bin[iff_pkg::BIN_W-2:0], 1'b0};
                n_step = r_step - 7'd1;
                if (r_step == 7'd1) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Zero itself keeps a single digit.
                if (r_dig[iff_pkg::DIG_W-1 -: 4] == 4'd0 && r_len > 5'd1) begin
                    n_dig = {r_dig[iff_pkg::DIG_W-5:0], 4'd0};
                    n_len = r_len - 5'd1;
                end else begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                // Wait here until the emitter has taken the previous field.
                if (!emit_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign start = (r_state == S_PLAN) && !emit_busy;

    // Field layout from the digit count and the held options.
    logic [5:0] prec_c;
    logic [6:0] fw_c;
    logic [6:0] zeros_p;
    logic [6:0] base_total;
    logic [6:0] pad;
    logic       sign_en;
    logic       pre_zero;
    logic       pre_x;
    logic       fill_zero;

    always_comb begin
        prec_c  = (r_prec > 6'(iff_pkg::PREC_CAP)) ? 6'(iff_pkg::PREC_CAP) : r_prec;
        fw_c    = (r_fwidth > 7'(iff_pkg::MAX_FIELD)) ? 7'(iff_pkg::MAX_FIELD) : r_fwidth;
        zeros_p = (r_pgiven && {1'b0, prec_c} > {2'b00, r_len})
                  ? ({1'b0, prec_c} - {2'b00, r_len}) : 7'd0;
        sign_en = r_neg || r_plus || r_space;
        // Hex prefix is 0x or 0X; the octal 0 is dropped when precision zero
        // fill already leads the digits.
        pre_x    = r_alt && r_nonzero && (r_radix == iff_pkg::RADIX_HEX);
        pre_zero = pre_x ||
                   (r_alt && r_nonzero && (r_radix == iff_pkg::RADIX_OCT) && zeros_p == 7'd0);
        base_total = {2'b00, r_len} + zeros_p + {6'd0, sign_en}
                     + {6'd0, pre_zero} + {6'd0, pre_x};
        pad        = (fw_c > base_total) ? (fw_c - base_total) : 7'd0;
        fill_zero  = r_zpad && !r_left && !r_pgiven;

        plan.lead_sp   = (!fill_zero && !r_left) ? pad : 7'd0;
        plan.trail_sp  = (!fill_zero && r_left) ? pad : 7'd0;
        plan.zeros     = fill_zero ? (zeros_p + pad) : zeros_p;
        plan.sign_en   = sign_en;
        plan.sign_char = r_neg ? iff_pkg::CH_MINUS
                       : (r_plus ? iff_pkg::CH_PLUS : iff_pkg::CH_SPACE);
        plan.pre_zero  = pre_zero;
        plan.pre_x     = pre_x;
        plan.x_char    = r_upper ? iff_pkg::CH_X_UP : iff_pkg::CH_X_LO;
        plan.len       = r_len;
        plan.total     = base_total + pad;
        plan.upper     = r_upper;
        plan.digits    = r_dig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 7'd0;
            r_len   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_len   <= n_len;
        end
        r_dig <= n_dig;
        r_bin <= n_bin;
        if (accept) begin
            r_neg     <= in_neg;
            r_nonzero <= (i_number != 64'd0);
            r_radix   <= i_radix_select;
            r_fwidth  <= i_field_width;
            r_prec    <= i_min_digits;
            r_pgiven  <= i_precision_given;
            r_zpad    <= i_zero_pad;
            r_left    <= i_left_justify;
            r_plus    <= i_force_plus;
            r_space   <= i_space_sign;
            r_alt     <= i_alternate_form;
            r_upper   <= i_upper_case;
        end
    end

    iff_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_plan      (plan),
        .o_busy      (emit_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
